/* rtl/assert_macros.svh */
// assertion helpers used by the checker of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define OBRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define OBRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/obrl_pkg.sv */
package obrl_pkg;

	// position, byte and read count widths fixed by the item fields
	localparam int POS_W  = 13;
	localparam int DATA_W = 8;
	localparam int CNT_W  = 7;

	// capacity after reset
	localparam logic [POS_W-1:0] CAP_RESET = 13'd4096;

	// result kinds
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	// request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// result descriptor from the sequencer to the output stage
	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   count;
		logic               last;
	} res_t;

endpackage

/* rtl/overwrite_byte_ring_log.sv */
// Byte ring log with overwrite. A write item stores one byte, unless its message
// already fills the capacity. A read item walks the read position one byte per
// cycle, while the result stage has room, through a single incrementing sequencer,
// and holds the input until it is done, with a wrap step when the read position
// sits at or past the capacity and first wraps. An empty read also holds the input.
// Results leave through the memory read register and an output register. The ring
// memory has no reset and needs no clearing pass; capacity may only change while
// the block is idle.
module overwrite_byte_ring_log #(
	parameter int RING_DEPTH = 4096,
	parameter int MAX_READ   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [obrl_pkg::POS_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [obrl_pkg::DATA_W-1:0] data_byte,
	input  logic                        write_last,
	input  logic [obrl_pkg::CNT_W-1:0]  read_max,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [obrl_pkg::DATA_W-1:0] read_data,
	output logic [obrl_pkg::POS_W-1:0]  byte_count,
	output logic                        last
);

	localparam int AW = $clog2(RING_DEPTH);

	logic [obrl_pkg::POS_W-1:0]  capacity_q;
	logic                        slot_free;
	logic                        push;
	obrl_pkg::res_t              push_res;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [obrl_pkg::DATA_W-1:0] wdata;
	logic                        re;
	logic [AW-1:0]               raddr;
	logic [obrl_pkg::DATA_W-1:0] rdata;

	// capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= obrl_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// sequencer
	obrl_seq #(
		.RING_DEPTH(RING_DEPTH),
		.MAX_READ  (MAX_READ),
		.AW        (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.data_byte (data_byte),
		.write_last(write_last),
		.read_max  (read_max),
		.slot_free (slot_free),
		.push      (push),
		.push_res  (push_res),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr)
	);

	// ring memory
	obrl_ram #(
		.DEPTH(RING_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// result stages
	obrl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.rdata     (rdata),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.read_data (read_data),
		.byte_count(byte_count),
		.last      (last)
	);

endmodule

/* rtl/obrl_ram.sv */
module obrl_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [obrl_pkg::DATA_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [obrl_pkg::DATA_W-1:0] rdata
);

	logic [obrl_pkg::DATA_W-1:0] mem [DEPTH];
	logic [obrl_pkg::DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/obrl_seq.sv */
module obrl_seq #(
	parameter int RING_DEPTH = 4096,
	parameter int MAX_READ   = 64,
	parameter int AW         = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [obrl_pkg::POS_W-1:0]  capacity,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [obrl_pkg::DATA_W-1:0] data_byte,
	input  logic                        write_last,
	input  logic [obrl_pkg::CNT_W-1:0]  read_max,
	input  logic                        slot_free,
	output logic                        push,
	output obrl_pkg::res_t              push_res,
	output logic                        we,
	output logic [AW-1:0]               waddr,
	output logic [obrl_pkg::DATA_W-1:0] wdata,
	output logic                        re,
	output logic [AW-1:0]               raddr
);

	localparam int PW = obrl_pkg::POS_W;
	localparam int CW = obrl_pkg::CNT_W;
	localparam int POS_MAX = (1 << PW) - 1;
	localparam logic [PW-1:0] DEPTH_LIM = PW'((RING_DEPTH > POS_MAX) ? POS_MAX : RING_DEPTH);
	localparam logic [CW-1:0] MAX_N = CW'(MAX_READ);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FWD,
		S_WRAP
	} state_t;

	state_t          state_q;
	logic [PW-1:0]   wr_pos_q;
	logic [PW-1:0]   rd_pos_q;
	logic [PW-1:0]   msg_q;
	logic [PW-1:0]   snap_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   count_q;

	logic            accept;
	logic [PW-1:0]   cap;
	logic [PW-1:0]   wr_slot;
	logic            store;
	logic [PW-1:0]   msg_next;
	logic [CW-1:0]   n_req;
	logic [PW-1:0]   rd_inc;
	logic            fwd_byte;
	logic            fwd_last;
	logic            wrap_byte;
	logic            wrap_last;

	// effective capacity, 0 acts as 1 and large values clamp to the ring
	always_comb begin
		if (capacity == '0) begin
			cap = PW'(1);
		end else if (capacity > DEPTH_LIM) begin
			cap = DEPTH_LIM;
		end else begin
			cap = capacity;
		end
	end

	assign in_stall = (state_q != S_IDLE) || !slot_free;
	assign accept   = in_valid && !in_stall;

	// write side: wrap the slot, count the message bytes
	assign wr_slot  = (wr_pos_q >= cap) ? '0 : wr_pos_q;
	assign store    = msg_q < cap;
	assign msg_next = store ? msg_q + PW'(1) : msg_q;

	// read side: shared step of the read position
	assign n_req     = (read_max > MAX_N) ? MAX_N : read_max;
	assign rd_inc    = rd_pos_q + PW'(1);
	assign fwd_byte  = (rem_q != '0) && (rd_pos_q < cap);
	assign fwd_last  = (rem_q == CW'(1)) || ((rd_inc == cap) && (snap_q == '0));
	assign wrap_byte = (rem_q != '0) && (rd_pos_q < snap_q);
	assign wrap_last = (rem_q == CW'(1)) || (rd_inc == snap_q);

	// memory ports and result pushes
	always_comb begin
		push     = 1'b0;
		push_res = '{kind: obrl_pkg::KIND_WRITE, count: '0, last: 1'b1};
		we       = 1'b0;
		waddr    = AW'(wr_slot);
		wdata    = data_byte;
		re       = 1'b0;
		raddr    = AW'(rd_pos_q);
		case (state_q)
			S_IDLE: begin
				if (accept && (req_type == obrl_pkg::REQ_WRITE)) begin
					we = store;
					if (write_last) begin
						push           = 1'b1;
						push_res.count = msg_next;
					end
				end
			end
			S_FWD: begin
				if (fwd_byte && slot_free) begin
					push     = 1'b1;
					re       = 1'b1;
					push_res = '{kind: obrl_pkg::KIND_BYTE,
						count: PW'(count_q + CW'(1)), last: fwd_last};
				end
			end
			S_WRAP: begin
				if (wrap_byte) begin
					if (slot_free) begin
						push     = 1'b1;
						re       = 1'b1;
						push_res = '{kind: obrl_pkg::KIND_BYTE,
							count: PW'(count_q + CW'(1)), last: wrap_last};
					end
				end else if (slot_free && (count_q == '0)) begin
					push     = 1'b1;
					push_res = '{kind: obrl_pkg::KIND_EMPTY, count: '0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer state and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wr_pos_q <= '0;
			rd_pos_q <= '0;
			msg_q    <= '0;
			snap_q   <= '0;
			rem_q    <= '0;
			count_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == obrl_pkg::REQ_WRITE) begin
							if (store) begin
								wr_pos_q <= wr_slot + PW'(1);
							end
							msg_q <= write_last ? '0 : msg_next;
						end else begin
							rem_q   <= n_req;
							snap_q  <= wr_pos_q;
							count_q <= '0;
							if ((n_req != '0) && (rd_pos_q > wr_pos_q)) begin
								state_q <= S_FWD;
							end else begin
								state_q <= S_WRAP;
							end
						end
					end
				end
				S_FWD: begin
					if (fwd_byte) begin
						if (slot_free) begin
							rd_pos_q <= (rd_inc == cap) ? '0 : rd_inc;
							rem_q    <= rem_q - CW'(1);
							count_q  <= count_q + CW'(1);
							if (fwd_last) begin
								state_q <= S_IDLE;
							end else if (rd_inc == cap) begin
								state_q <= S_WRAP;
							end
						end
					end else begin
						// read position at or past the end: wrap to the start
						if (rd_pos_q >= cap) begin
							rd_pos_q <= '0;
						end
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (wrap_byte) begin
						if (slot_free) begin
							rd_pos_q <= rd_inc;
							rem_q    <= rem_q - CW'(1);
							count_q  <= count_q + CW'(1);
							if (wrap_last) begin
								state_q <= S_IDLE;
							end
						end
					end else if (slot_free || (count_q != '0)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/obrl_out.sv */
module obrl_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  obrl_pkg::res_t              push_res,
	input  logic [obrl_pkg::DATA_W-1:0] rdata,
	output logic                        slot_free,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [obrl_pkg::DATA_W-1:0] read_data,
	output logic [obrl_pkg::POS_W-1:0]  byte_count,
	output logic                        last
);

	logic                        valid_s1;
	obrl_pkg::res_t              res_s1;
	logic                        out_valid_q;
	logic [1:0]                  kind_q;
	logic [obrl_pkg::DATA_W-1:0] data_q;
	logic [obrl_pkg::POS_W-1:0]  count_q;
	logic                        last_q;
	logic                        advance;

	// stage 1 moves on when the output register is empty or being taken
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign slot_free = !valid_s1 || advance;

	// stage 1 waits for the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (push) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_s1 <= push_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q  <= res_s1.kind;
			data_q  <= (res_s1.kind == obrl_pkg::KIND_BYTE) ? rdata : '0;
			count_q <= res_s1.count;
			last_q  <= res_s1.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign read_data  = data_q;
	assign byte_count = count_q;
	assign last       = last_q;

endmodule

/* rtl/obrl_chk.sv */
`include "assert_macros.svh"

module obrl_chk #(
	parameter int MAX_READ = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  kind,
	input logic [obrl_pkg::DATA_W-1:0] read_data,
	input logic [obrl_pkg::POS_W-1:0]  byte_count,
	input logic                        last
);

	localparam logic [obrl_pkg::POS_W-1:0] MAX_CNT = obrl_pkg::POS_W'(MAX_READ);

	// a stalled result holds
	`OBRL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(read_data) && $stable(byte_count) && $stable(last), "stalled result changed")

	// a write result closes its item and counts at least one byte
	`OBRL_ASSERT_NOW(a_write_res, clk, arst_n, out_valid && (kind == obrl_pkg::KIND_WRITE), last && (byte_count != '0) && (read_data == '0), "bad write result")

	// an empty read is a single zero result
	`OBRL_ASSERT_NOW(a_empty_res, clk, arst_n, out_valid && (kind == obrl_pkg::KIND_EMPTY), last && (byte_count == '0) && (read_data == '0), "bad empty read result")

	// a read byte count stays within the request limit
	`OBRL_ASSERT_NOW(a_byte_cnt, clk, arst_n, out_valid && (kind == obrl_pkg::KIND_BYTE), (byte_count != '0) && (byte_count <= MAX_CNT), "read byte count out of range")

endmodule

bind overwrite_byte_ring_log obrl_chk #(.MAX_READ(MAX_READ)) u_obrl_chk (.*);
